// ===== hw/rtl/mcfd_pkg.sv =====
package mcfd_pkg;

	// field and register widths
	localparam int STAMP_W  = 16;
	localparam int TEMPO_W  = 10;
	localparam int CNT_W    = 16;
	localparam int PHASE_W  = 3;
	localparam int WEIGHT_W = 9;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEND_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLL_WEIGHT  = 2'd2;

	// tempo to step interval: interval = TEMPO_NUM / bpm - TEMPO_OFS
	localparam int DIV_W = 18;
	localparam logic [DIV_W-1:0]   TEMPO_NUM    = 18'd156250;
	localparam logic [TEMPO_W-1:0] TEMPO_MIN    = 10'd3;
	localparam logic [CNT_W-1:0]   TEMPO_OFS    = 16'd16;
	localparam logic [CNT_W-1:0]   INTERVAL_RST = 16'd1286;

	// smoothing weight, out of WEIGHT_ONE
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd220;

	// six 96th steps to a 16th, a 32nd at the start and the middle
	localparam logic [PHASE_W-1:0] PHASE_WRAP = 3'd6;
	localparam logic [PHASE_W-1:0] PHASE_MID  = 3'd3;

	// phase correction gain, out of 256, range 1 to 128
	localparam int PHASE_GAIN = 16;
	localparam int GAIN_W     = 8;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_CLOCK     = 3'd1,
		CMD_EXT_START = 3'd2,
		CMD_EXT_STOP  = 3'd3,
		CMD_INT_START = 3'd4,
		CMD_INT_STOP  = 3'd5,
		CMD_PAUSE     = 3'd6,
		CMD_TEMPO     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_INT      = 2'd1,
		MODE_EXT_MIDI = 2'd2,
		MODE_EXT_UART = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		BYTE_NONE  = 2'd0,
		BYTE_CLOCK = 2'd1,
		BYTE_START = 2'd2,
		BYTE_STOP  = 2'd3
	} byte_code_t;

	typedef enum logic [1:0] {
		RUN_PAUSED   = 2'd0,
		RUN_STARTING = 2'd1,
		RUN_STARTED  = 2'd2
	} run_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [STAMP_W-1:0] timestamp;
		logic [TEMPO_W-1:0] tempo_bpm;
	} evt_t;

	typedef struct packed {
		logic             pulse_96th;
		logic             pulse_32nd;
		logic             pulse_16th;
		byte_code_t       midi_byte_code;
		logic [CNT_W-1:0] count_96th;
		logic [CNT_W-1:0] count_32nd;
		logic [CNT_W-1:0] count_16th;
		run_t             run_status;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic fix;
		logic mul;
		logic mac;
		logic div_start;
		logic div_load;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tempo;
		logic need_fix;
		logic need_smooth;
		logic div_done;
	} dp_stat_t;

endpackage

// ===== hw/rtl/midi_clock_follower_divider.sv =====
// MIDI clock follower and divider. Each word on the event channel is a timer tick, an
// incoming MIDI clock pulse with its timestamp, a start, stop or pause command, or a new
// tempo, and every word gives exactly one result word: the 96th, 32nd and 16th pulses of
// that tick, the MIDI byte to send, the running step counts and the run status. Timer
// ticks and most commands pass through the execute and done states from acceptance until
// the result is registered; a tick that reloads the countdown in an external mode also
// passes the fix state for the phase correction, a smoothed clock pulse the multiply and
// accumulate states of the weighted average, and a tempo change the divide state, where
// it waits for the restoring divider that yields one quotient bit per cycle. A new event is
// taken as soon as the previous one has reached the result register, even while that
// result still waits downstream. Configuration writes are taken at any time but belong
// to idle periods.
module midi_clock_follower_divider
	import mcfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  evt_t                 evt,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	mcfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	mcfd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.res       (res)
	);

endmodule

// ===== hw/rtl/mcfd_div.sv =====
module mcfd_div
	import mcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TEMPO_W-1:0] divisor,
	output logic [DIV_W-1:0]   quotient,
	output logic               done
);

	localparam int STEP_W = $clog2(DIV_W + 1);

	logic [STEP_W-1:0]  step_q;
	logic               done_q;
	logic [TEMPO_W-1:0] rem_q;
	logic [TEMPO_W-1:0] dsr_q;
	logic [DIV_W-1:0]   quo_q;

	logic [TEMPO_W:0]   shifted;
	logic [TEMPO_W:0]   diff;
	logic               fits;

	// restoring division, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(DIV_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= TEMPO_NUM;
		end else if (step_q != '0) begin
			rem_q <= fits ? diff[TEMPO_W-1:0] : shifted[TEMPO_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/mcfd_dp.sv =====
module mcfd_dp
	import mcfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  evt_t                 evt,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat,
	output res_t                 res
);

	localparam int PROD_W = CNT_W + WEIGHT_W;

	// settings
	mode_t               mode_q;
	logic                send_q;
	logic [WEIGHT_W-1:0] weight_q;

	// follower state
	run_t               run_q;
	logic [CNT_W-1:0]   countdown_q;
	logic [CNT_W-1:0]   interval_q;
	logic [STAMP_W-1:0] prev_stamp_q;
	logic [CNT_W-1:0]   gen_steps_q;
	logic [PHASE_W-1:0] gen_phase_q;
	logic [CNT_W-1:0]   gen_32_q;
	logic [CNT_W-1:0]   gen_16_q;
	logic [CNT_W-1:0]   recv_steps_q;
	logic [PHASE_W-1:0] recv_phase_q;

	// per-word working registers
	evt_t               item_q;
	logic [STAMP_W-1:0] gap_q;
	logic [PROD_W-1:0]  prod_q;
	logic               p96_q;
	logic               p32_q;
	logic               p16_q;
	byte_code_t         byte_q;
	res_t               res_q;

	logic               ext;
	logic               is_tick;
	logic               is_clock;
	logic               cd_zero;
	logic               p96_n;
	logic               p32_n;
	logic               p16_n;
	logic               do_start;
	logic               do_stop;
	byte_code_t         byte_n;
	logic [STAMP_W-1:0] gap_now;
	logic [CNT_W-1:0]   recv_next;
	logic [PHASE_W-1:0] recv_phase_inc;
	logic [PHASE_W-1:0] gen_phase_inc;
	logic [WEIGHT_W-1:0] w_eff;
	logic [PROD_W-1:0]  mac_sum;
	logic               sync;
	logic               behind;
	logic [CNT_W-1:0]   dec;
	logic [CNT_W-1:0]   inc;
	logic [CNT_W:0]     grown;
	logic [TEMPO_W-1:0] tempo_cl;
	logic [DIV_W-1:0]   quotient;
	logic [DIV_W-1:0]   interval_div;
	logic               div_done;

	// a gap across the wrap is one short of the modular difference
	function automatic logic [STAMP_W-1:0] stamp_gap(input logic [STAMP_W-1:0] older,
		input logic [STAMP_W-1:0] newer);
		if (newer >= older)
			return newer - older;
		return newer - older - 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] gain_of(input logic [CNT_W-1:0] v);
		logic [CNT_W+GAIN_W-1:0] p;
		p = {{GAIN_W{1'b0}}, v} * (CNT_W + GAIN_W)'(PHASE_GAIN);
		return p[CNT_W+GAIN_W-1:GAIN_W];
	endfunction

	assign ext      = (mode_q == MODE_EXT_MIDI) || (mode_q == MODE_EXT_UART);
	assign is_tick  = item_q.cmd == CMD_TICK;
	assign is_clock = item_q.cmd == CMD_CLOCK;
	assign cd_zero  = countdown_q == '0;

	assign p96_n = is_tick && cd_zero;
	assign p16_n = p96_n && (gen_phase_q == '0);
	assign p32_n = p96_n && ((gen_phase_q == '0) || (gen_phase_q == PHASE_MID));

	assign do_start = (mode_q == MODE_INT) && ((item_q.cmd == CMD_INT_START) ||
		((item_q.cmd == CMD_PAUSE) && (run_q == RUN_PAUSED)));
	assign do_stop  = (mode_q == MODE_INT) && ((item_q.cmd == CMD_INT_STOP) ||
		((item_q.cmd == CMD_PAUSE) && (run_q != RUN_PAUSED)));

	always_comb begin
		byte_n = BYTE_NONE;
		if (send_q) begin
			if (do_start)
				byte_n = BYTE_START;
			else if (do_stop)
				byte_n = BYTE_STOP;
			else if (p96_n && (mode_q == MODE_INT))
				byte_n = BYTE_CLOCK;
		end
	end

	assign gap_now        = stamp_gap(prev_stamp_q, item_q.timestamp);
	assign recv_next      = recv_steps_q + 1'b1;
	assign recv_phase_inc = recv_phase_q + 1'b1;
	assign gen_phase_inc  = gen_phase_q + 1'b1;

	// smoothing
	assign w_eff   = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
	assign mac_sum = prod_q + {{WEIGHT_W{1'b0}}, gap_q} *
		{{CNT_W{1'b0}}, WEIGHT_ONE - w_eff};

	// phase correction against the received count
	assign sync   = (gen_steps_q < recv_steps_q) ||
		({1'b0, gen_steps_q} > ({1'b0, recv_steps_q} + 1'b1));
	assign behind = sync || (gen_steps_q <= recv_steps_q);
	assign dec    = gain_of(gap_q);
	assign inc    = gain_of(countdown_q - gap_q);
	assign grown  = {1'b0, countdown_q} + {1'b0, inc};

	assign tempo_cl     = (item_q.tempo_bpm < TEMPO_MIN) ? TEMPO_MIN : item_q.tempo_bpm;
	assign interval_div = quotient - DIV_W'(TEMPO_OFS);

	mcfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (tempo_cl),
		.quotient (quotient),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OFF;
			send_q       <= 1'b0;
			weight_q     <= WEIGHT_RST;
			run_q        <= RUN_PAUSED;
			countdown_q  <= '0;
			interval_q   <= INTERVAL_RST;
			prev_stamp_q <= '0;
			gen_steps_q  <= '0;
			gen_phase_q  <= '0;
			gen_32_q     <= '0;
			gen_16_q     <= '0;
			recv_steps_q <= '0;
			recv_phase_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CLOCK_MODE:  mode_q   <= mode_t'(cfg_data[1:0]);
					CFG_SEND_ENABLE: send_q   <= cfg_data[0];
					CFG_PLL_WEIGHT:  weight_q <= cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end

			if (cmd.exec) begin
				case (item_q.cmd)
					CMD_TICK: begin
						if (cd_zero) begin
							countdown_q <= interval_q;
							gen_steps_q <= gen_steps_q + 1'b1;
							gen_phase_q <= (gen_phase_inc == PHASE_WRAP) ? '0 : gen_phase_inc;
							if (p16_n)
								gen_16_q <= gen_16_q + 1'b1;
							if (p32_n)
								gen_32_q <= gen_32_q + 1'b1;
						end else begin
							countdown_q <= countdown_q - 1'b1;
						end
					end
					CMD_CLOCK: begin
						prev_stamp_q <= item_q.timestamp;
						recv_steps_q <= recv_next;
						recv_phase_q <= (recv_phase_inc == PHASE_WRAP) ? '0 : recv_phase_inc;
						if (run_q == RUN_STARTING)
							run_q <= RUN_STARTED;
						else if ((run_q == RUN_STARTED) && (recv_next == CNT_W'(2)))
							interval_q <= gap_now;
					end
					CMD_EXT_START: begin
						if (ext) begin
							run_q        <= RUN_STARTING;
							countdown_q  <= '0;
							prev_stamp_q <= '0;
							gen_steps_q  <= '0;
							gen_phase_q  <= '0;
							gen_32_q     <= '0;
							gen_16_q     <= '0;
							recv_steps_q <= '0;
							recv_phase_q <= '0;
							weight_q     <= WEIGHT_RST;
						end
					end
					CMD_EXT_STOP: begin
						if (ext)
							run_q <= RUN_PAUSED;
					end
					default: begin
						if (do_start) begin
							run_q       <= RUN_STARTED;
							gen_steps_q <= '0;
							gen_phase_q <= '0;
							gen_32_q    <= '0;
							gen_16_q    <= '0;
						end else if (do_stop) begin
							run_q <= RUN_PAUSED;
						end
					end
				endcase
			end

			if (cmd.fix) begin
				if (sync) begin
					gen_steps_q <= recv_steps_q;
					gen_phase_q <= recv_phase_q;
				end
				if (behind)
					countdown_q <= (countdown_q > dec) ? countdown_q - dec : '0;
				else if (countdown_q > gap_q)
					countdown_q <= grown[CNT_W] ? '1 : grown[CNT_W-1:0];
			end

			if (cmd.mac)
				interval_q <= mac_sum[CNT_W+7:8];

			if (cmd.div_load)
				interval_q <= interval_div[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= evt;
		if (cmd.exec) begin
			gap_q  <= gap_now;
			p96_q  <= p96_n;
			p32_q  <= p32_n;
			p16_q  <= p16_n;
			byte_q <= byte_n;
		end
		if (cmd.mul)
			prod_q <= {{WEIGHT_W{1'b0}}, interval_q} * {{CNT_W{1'b0}}, w_eff};
		if (cmd.emit) begin
			res_q.pulse_96th     <= p96_q;
			res_q.pulse_32nd     <= p32_q;
			res_q.pulse_16th     <= p16_q;
			res_q.midi_byte_code <= byte_q;
			res_q.count_96th     <= gen_steps_q;
			res_q.count_32nd     <= gen_32_q;
			res_q.count_16th     <= gen_16_q;
			res_q.run_status     <= run_q;
		end
	end

	assign stat.is_tempo    = item_q.cmd == CMD_TEMPO;
	assign stat.need_fix    = p96_n && ext;
	assign stat.need_smooth = is_clock && (run_q == RUN_STARTED) && (recv_next != CNT_W'(2));
	assign stat.div_done    = div_done;
	assign res              = res_q;

endmodule

// ===== hw/rtl/mcfd_ctrl.sv =====
module mcfd_ctrl
	import mcfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_stall,
	output logic      res_valid,
	input  logic      res_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIX,
		ST_MUL,
		ST_MAC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   accept;
	logic   emit;

	assign accept = (state_q == ST_IDLE) && evt_valid;
	// the result register frees up in the same cycle it is taken
	assign emit   = (state_q == ST_DONE) && (!out_valid_q || !res_stall);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (evt_valid) state_n = ST_EXEC;
			ST_EXEC: begin
				if (stat.is_tempo)
					state_n = ST_DIV;
				else if (stat.need_fix)
					state_n = ST_FIX;
				else if (stat.need_smooth)
					state_n = ST_MUL;
				else
					state_n = ST_DONE;
			end
			ST_FIX:  state_n = ST_DONE;
			ST_MUL:  state_n = ST_MAC;
			ST_MAC:  state_n = ST_DONE;
			ST_DIV:  if (stat.div_done) state_n = ST_DONE;
			ST_DONE: if (emit) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= emit || (out_valid_q && res_stall);
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.exec      = state_q == ST_EXEC;
		cmd.div_start = (state_q == ST_EXEC) && stat.is_tempo;
		cmd.fix       = state_q == ST_FIX;
		cmd.mul       = state_q == ST_MUL;
		cmd.mac       = state_q == ST_MAC;
		cmd.div_load  = (state_q == ST_DIV) && stat.div_done;
		cmd.emit      = emit;
	end

	assign evt_stall = state_q != ST_IDLE;
	assign res_valid = out_valid_q;

endmodule

// ===== hw/rtl/mcfd_chk.sv =====
module mcfd_chk
	import mcfd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 evt_valid,
	input logic                 evt_stall,
	input evt_t                 evt,
	input logic                 res_valid,
	input logic                 res_stall,
	input res_t                 res,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed under stall");

	// the block is busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall |=> evt_stall)
		else $error("second word taken before the first was worked");

	// a fresh result only follows a busy cycle
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(evt_stall))
		else $error("result appeared without work");

	// a 16th or 32nd pulse is always a 96th step, never with a start or stop byte
	a_pulse_nesting: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.pulse_16th || res.pulse_32nd) |->
		res.pulse_96th && (res.midi_byte_code == BYTE_NONE ||
		res.midi_byte_code == BYTE_CLOCK))
		else $error("divided pulse without a 96th step");

endmodule

bind midi_clock_follower_divider mcfd_chk u_mcfd_chk (.*);

// ===== bench/mcfd_result_check.sv =====
`timescale 1ns / 100ps
module mcfd_result_check
	import mcfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	input  logic                 evt_stall,
	input  evt_t                 evt,
	input  logic                 res_valid,
	input  logic                 res_stall,
	input  res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          outstanding,
	output int unsigned          mismatches
);

	// register copies
	mode_t               mode_r;
	logic                send_r;
	logic [WEIGHT_W-1:0] weight_r;

	// follower state
	run_t               run_st;
	logic [CNT_W-1:0]   cdown;
	logic [CNT_W-1:0]   interval;
	logic [STAMP_W-1:0] last_stamp;
	logic [CNT_W-1:0]   steps96;
	logic [CNT_W-1:0]   steps32;
	logic [CNT_W-1:0]   steps16;
	logic [CNT_W-1:0]   rx_steps;
	logic [PHASE_W-1:0] phase96;
	logic [PHASE_W-1:0] rx_phase;

	res_t        due_results[$];
	res_t        oldest_due;
	int unsigned words_seen;

	task automatic report_miss(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("%0t: result word %0d, %s: got %0h, want %0h",
				$realtime, words_seen, what, got, want);
		mismatches = mismatches + 1;
	endtask

	function automatic logic following_external();
		return mode_r == MODE_EXT_MIDI || mode_r == MODE_EXT_UART;
	endfunction

	// gap across the 16-bit wrap is new + 65535 - old, equal stamps give 0
	function automatic logic [31:0] stamp_span(input logic [STAMP_W-1:0] older,
			input logic [STAMP_W-1:0] newer);
		if (newer >= older)
			return {16'd0, newer} - {16'd0, older};
		return {16'd0, newer} + 32'd65535 - {16'd0, older};
	endfunction

	function automatic void clear_follow_state();
		run_st     = RUN_PAUSED;
		cdown      = '0;
		last_stamp = '0;
		steps96    = '0;
		steps32    = '0;
		steps16    = '0;
		phase96    = '0;
		rx_steps   = '0;
		rx_phase   = '0;
		weight_r   = WEIGHT_RST;
	endfunction

	function automatic byte_code_t start_internal();
		run_st  = RUN_STARTED;
		phase96 = '0;
		steps96 = '0;
		steps32 = '0;
		steps16 = '0;
		return send_r ? BYTE_START : BYTE_NONE;
	endfunction

	function automatic byte_code_t stop_internal();
		run_st = RUN_PAUSED;
		return send_r ? BYTE_STOP : BYTE_NONE;
	endfunction

	function automatic res_t follow_event(input evt_t w);
		res_t               r;
		logic [31:0]        gap;
		logic [31:0]        d;
		logic [31:0]        t;
		logic [31:0]        wt;
		logic [TEMPO_W-1:0] bpm;
		r = '0;
		case (w.cmd)
		CMD_TICK: begin
			if (cdown == '0) begin
				cdown = interval;
				r.pulse_96th = 1'b1;
				if (phase96 == '0) begin
					r.pulse_16th = 1'b1;
					r.pulse_32nd = 1'b1;
					steps16 = steps16 + 1'b1;
					steps32 = steps32 + 1'b1;
				end
				if (phase96 == PHASE_MID) begin
					r.pulse_32nd = 1'b1;
					steps32 = steps32 + 1'b1;
				end
				steps96 = steps96 + 1'b1;
				phase96 = phase96 + 1'b1;
				if (following_external()) begin
					gap = stamp_span(last_stamp, w.timestamp);
					// snap to the received count when behind it or more than one step ahead
					if (steps96 < rx_steps || {16'd0, steps96} > {16'd0, rx_steps} + 32'd1) begin
						steps96 = rx_steps;
						phase96 = rx_phase;
					end
					if (steps96 <= rx_steps) begin
						d = (gap * PHASE_GAIN) >> 8;
						cdown = ({16'd0, cdown} > d) ? cdown - d[15:0] : '0;
					end else if ({16'd0, cdown} > gap) begin
						t = {16'd0, cdown} + ((({16'd0, cdown} - gap) * PHASE_GAIN) >> 8);
						cdown = (t > 32'd65535) ? 16'hFFFF : t[15:0];
					end
				end else if (mode_r == MODE_INT && send_r) begin
					r.midi_byte_code = BYTE_CLOCK;
				end
				if (phase96 == PHASE_WRAP)
					phase96 = '0;
			end else begin
				cdown = cdown - 1'b1;
			end
		end
		CMD_CLOCK: begin
			gap = stamp_span(last_stamp, w.timestamp);
			last_stamp = w.timestamp;
			rx_steps = rx_steps + 1'b1;
			rx_phase = rx_phase + 1'b1;
			if (rx_phase == PHASE_WRAP)
				rx_phase = '0;
			if (run_st == RUN_STARTING) begin
				run_st = RUN_STARTED;
			end else if (run_st == RUN_STARTED) begin
				if (rx_steps == 16'd2) begin
					interval = gap[15:0];
				end else begin
					wt = {23'd0, (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r};
					t = ({16'd0, interval} * wt + ({23'd0, WEIGHT_ONE} - wt) * gap) >> 8;
					interval = t[15:0];
				end
			end
		end
		CMD_EXT_START: begin
			if (following_external()) begin
				clear_follow_state();
				run_st = RUN_STARTING;
			end
		end
		CMD_EXT_STOP: begin
			if (following_external())
				run_st = RUN_PAUSED;
		end
		CMD_INT_START: begin
			if (mode_r == MODE_INT)
				r.midi_byte_code = start_internal();
		end
		CMD_INT_STOP: begin
			if (mode_r == MODE_INT)
				r.midi_byte_code = stop_internal();
		end
		CMD_PAUSE: begin
			if (mode_r == MODE_INT) begin
				if (run_st == RUN_PAUSED)
					r.midi_byte_code = start_internal();
				else
					r.midi_byte_code = stop_internal();
			end
		end
		default: begin
			bpm = (w.tempo_bpm < TEMPO_MIN) ? TEMPO_MIN : w.tempo_bpm;
			t = {14'd0, TEMPO_NUM} / {22'd0, bpm};
			interval = t[15:0] - TEMPO_OFS;
		end
		endcase
		r.count_96th = steps96;
		r.count_32nd = steps32;
		r.count_16th = steps16;
		r.run_status = run_st;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = MODE_OFF;
			send_r = 1'b0;
			interval = INTERVAL_RST;
			clear_follow_state();
			due_results.delete();
			words_seen = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				words_seen = words_seen + 1;
				if (due_results.size() == 0) begin
					report_miss("word with nothing due", 32'd0, 32'd0);
				end else begin
					oldest_due = due_results.pop_front();
					if (res.pulse_96th !== oldest_due.pulse_96th)
						report_miss("pulse_96th", 32'(res.pulse_96th),
							32'(oldest_due.pulse_96th));
					if (res.pulse_32nd !== oldest_due.pulse_32nd)
						report_miss("pulse_32nd", 32'(res.pulse_32nd),
							32'(oldest_due.pulse_32nd));
					if (res.pulse_16th !== oldest_due.pulse_16th)
						report_miss("pulse_16th", 32'(res.pulse_16th),
							32'(oldest_due.pulse_16th));
					if (res.midi_byte_code !== oldest_due.midi_byte_code)
						report_miss("midi_byte_code", 32'(res.midi_byte_code),
							32'(oldest_due.midi_byte_code));
					if (res.count_96th !== oldest_due.count_96th)
						report_miss("count_96th", 32'(res.count_96th),
							32'(oldest_due.count_96th));
					if (res.count_32nd !== oldest_due.count_32nd)
						report_miss("count_32nd", 32'(res.count_32nd),
							32'(oldest_due.count_32nd));
					if (res.count_16th !== oldest_due.count_16th)
						report_miss("count_16th", 32'(res.count_16th),
							32'(oldest_due.count_16th));
					if (res.run_status !== oldest_due.run_status)
						report_miss("run_status", 32'(res.run_status),
							32'(oldest_due.run_status));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_CLOCK_MODE: mode_r = mode_t'(cfg_data[1:0]);
				CFG_SEND_ENABLE: send_r = cfg_data[0];
				CFG_PLL_WEIGHT: weight_r = cfg_data[WEIGHT_W-1:0];
				default: ;
				endcase
			end
			if (evt_valid && !evt_stall)
				due_results.push_back(follow_event(evt));
			outstanding <= due_results.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import mcfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASES = 12;
	localparam int unsigned WORDS_PER_PHASE = 135;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 evt_valid = 1'b0;
	logic                 evt_stall;
	evt_t                 evt = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int unsigned          outstanding;
	int unsigned          mismatches;
	int unsigned          cycles = 0;
	int unsigned          hold = 0;
	logic                 quiet = 1'b0;
	logic [STAMP_W-1:0]   now_stamp = '0;

	midi_clock_follower_divider dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mcfd_result_check follow_check (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: after each word taken, hold off for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin : rx_pace
		int unsigned n;
		if (!arst_n) begin
			hold <= 0;
			res_stall <= 1'b0;
		end else if (res_valid && !res_stall) begin
			n = quiet ? 0 : $urandom_range(0, 9);
			hold <= n;
			res_stall <= (n != 0);
		end else if (hold != 0) begin
			hold <= hold - 1;
			res_stall <= (hold != 1);
		end
	end

	task automatic send_word(input cmd_t c, input logic [STAMP_W-1:0] stamp,
			input logic [TEMPO_W-1:0] bpm);
		int unsigned gap;
		evt_t        w;
		gap = quiet ? 0 : $urandom_range(0, 9);
		w.cmd = c;
		w.timestamp = stamp;
		w.tempo_bpm = bpm;
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= w;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (evt_stall) @(posedge clk);
	endtask

	task automatic load_setup(input mode_t m, input logic send, input logic [WEIGHT_W-1:0] wt);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLOCK_MODE;
		cfg_data <= {{(CFG_W-2){1'b0}}, m};
		@(posedge clk);
		cfg_index <= CFG_SEND_ENABLE;
		cfg_data <= {{(CFG_W-1){1'b0}}, send};
		@(posedge clk);
		cfg_index <= CFG_PLL_WEIGHT;
		cfg_data <= wt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for every expected word, then let the block go quiet
	task automatic settle();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly small steps so measured gaps stay short, now and then a repeat or a jump
	function automatic logic [STAMP_W-1:0] next_stamp();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 1)
			now_stamp = STAMP_W'($urandom_range(0, 65535));
		else if (roll >= 6)
			now_stamp = now_stamp + STAMP_W'($urandom_range(1, 12));
		return now_stamp;
	endfunction

	task automatic random_word(input mode_t m);
		int unsigned        roll;
		cmd_t               c;
		logic [TEMPO_W-1:0] bpm;
		roll = $urandom_range(0, 99);
		bpm = ($urandom_range(0, 9) == 0) ? TEMPO_W'($urandom_range(0, 3)) :
			TEMPO_W'($urandom_range(0, 1023));
		if (roll < 5) begin
			c = cmd_t'($urandom_range(0, 7));
		end else if (m == MODE_EXT_MIDI || m == MODE_EXT_UART) begin
			if (roll < 55) c = CMD_TICK;
			else if (roll < 88) c = CMD_CLOCK;
			else if (roll < 92) c = CMD_EXT_START;
			else if (roll < 94) c = CMD_EXT_STOP;
			else if (roll < 96) c = CMD_TEMPO;
			else c = cmd_t'($urandom_range(4, 6));
		end else if (m == MODE_INT) begin
			if (roll < 60) c = CMD_TICK;
			else if (roll < 84) c = CMD_CLOCK;
			else if (roll < 87) c = CMD_INT_START;
			else if (roll < 90) c = CMD_INT_STOP;
			else if (roll < 94) c = CMD_PAUSE;
			else if (roll < 96) c = CMD_TEMPO;
			else c = cmd_t'($urandom_range(2, 3));
		end else begin
			c = (roll < 50) ? CMD_TICK : cmd_t'($urandom_range(1, 7));
		end
		send_word(c, next_stamp(), bpm);
	endtask

	initial begin : stimulus
		mode_t               m;
		logic                send;
		logic [WEIGHT_W-1:0] wt;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tempo extremes and commands that the off mode ignores
		load_setup(MODE_OFF, 1'b0, WEIGHT_RST);
		send_word(CMD_TICK, 16'h0000, 10'h000);
		send_word(CMD_TEMPO, 16'hFFFF, 10'd0);
		send_word(CMD_TEMPO, 16'h0000, 10'd2);
		send_word(CMD_TEMPO, 16'h0000, 10'd1023);
		send_word(CMD_INT_START, 16'h0000, 10'h3FF);
		send_word(CMD_EXT_START, 16'hFFFF, 10'h000);
		send_word(CMD_PAUSE, 16'h0000, 10'h155);
		send_word(CMD_CLOCK, 16'hFFFF, 10'h2AA);
		settle();

		// countdown pulled down to zero by a long gap, then stop and a repeated stamp
		load_setup(MODE_EXT_UART, 1'b1, WEIGHT_ONE);
		send_word(CMD_EXT_START, 16'd0, 10'd0);
		send_word(CMD_CLOCK, 16'd5, 10'd0);
		send_word(CMD_TICK, 16'd60000, 10'd0);
		send_word(CMD_EXT_STOP, 16'd60000, 10'd0);
		send_word(CMD_CLOCK, 16'd5, 10'd0);
		settle();

		// wrapped gap sets a huge interval, a leading step then saturates the countdown
		load_setup(MODE_EXT_MIDI, 1'b0, 9'd0);
		send_word(CMD_EXT_START, 16'd0, 10'd0);
		send_word(CMD_CLOCK, 16'd100, 10'd0);
		send_word(CMD_CLOCK, 16'd50, 10'd0);
		send_word(CMD_EXT_START, 16'd0, 10'd0);
		send_word(CMD_TICK, 16'd0, 10'd0);
		settle();

		// internal start and stop bytes, weight above full scale, equal stamps
		load_setup(MODE_INT, 1'b1, 9'd511);
		send_word(CMD_INT_START, 16'd0, 10'd0);
		send_word(CMD_CLOCK, 16'd7, 10'd0);
		send_word(CMD_CLOCK, 16'd7, 10'd0);
		send_word(CMD_TICK, 16'd9, 10'd0);
		send_word(CMD_PAUSE, 16'd9, 10'd0);
		send_word(CMD_PAUSE, 16'd9, 10'd0);
		send_word(CMD_INT_STOP, 16'd9, 10'd0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 6)
			0: m = MODE_EXT_MIDI;
			2: m = MODE_EXT_UART;
			4: m = MODE_OFF;
			default: m = MODE_INT;
			endcase
			case (p % 4)
			0: wt = 9'd0;
			1: wt = WEIGHT_ONE;
			2: wt = 9'd511;
			default: wt = WEIGHT_W'($urandom_range(0, 511));
			endcase
			send = (p % 3 != 0);
			quiet = ($urandom_range(0, 3) == 0);
			load_setup(m, send, wt);
			// each internal or external phase opens with a well-formed start
			if (m == MODE_EXT_MIDI || m == MODE_EXT_UART)
				send_word(CMD_EXT_START, next_stamp(), TEMPO_W'($urandom_range(0, 1023)));
			else if (m == MODE_INT)
				send_word(CMD_INT_START, next_stamp(), TEMPO_W'($urandom_range(0, 1023)));
			for (int i = 1; i < WORDS_PER_PHASE; i++)
				random_word(m);
			settle();
		end

		quiet = 1'b0;
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
